[rtl/irc_lfp_pkg.sv]
`default_nettype none
package irc_lfp_pkg;

   // Defaults for the top-level parameters
   localparam int LINE_LIMIT_DEF = 512;
   localparam int QUEUE_DEPTH_DEF = 4;

   // Width of the reported offset and length fields
   localparam int FIELD_W = 10;

   // Delimiter characters
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_AT    = 8'h40;
   localparam logic [7:0] CH_SPACE = 8'h20;

   typedef enum logic [3:0] {
      PH_INIT     = 4'd0,
      PH_NICK     = 4'd1,
      PH_NAME     = 4'd2,
      PH_HOST     = 4'd3,
      PH_COMMAND  = 4'd4,
      PH_PARAMS   = 4'd5,
      PH_TRAILING = 4'd6,
      PH_END      = 4'd7,
      PH_ERROR    = 4'd8
   } phase_type;

   typedef enum logic [2:0] {
      EV_NICK    = 3'd0,
      EV_NAME    = 3'd1,
      EV_HOST    = 3'd2,
      EV_COMMAND = 3'd3,
      EV_PARAM   = 3'd4,
      EV_END     = 3'd5,
      EV_ERROR   = 3'd6
   } ev_type;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_LONG     = 2'd1,
      ERR_LF       = 2'd2,
      ERR_AFTER_CR = 2'd3
   } err_type;

   // One queued command: a single event, or a param event followed by end of line
   typedef struct packed {
      ev_type               kind;
      logic [FIELD_W-1:0]   start;
      logic [FIELD_W-1:0]   len;
      err_type              code;
      logic                 pair;
   } q_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage
`default_nettype wire

[rtl/irc_lfp_if.sv]
`default_nettype none
interface irc_lfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

interface irc_lfp_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] event_kind;
   logic [9:0] field_start;
   logic [9:0] field_length;
   logic [1:0] error_code;
   logic       last_of_run;

   modport source (output valid, output event_kind, output field_start,
                   output field_length, output error_code, output last_of_run,
                   input ready);
   modport sink (input valid, input event_kind, input field_start,
                 input field_length, input error_code, input last_of_run,
                 output ready);
endinterface
`default_nettype wire

[rtl/irc_lfp_front.sv]
`default_nettype none
module irc_lfp_front
   import irc_lfp_pkg::*;
#(
   parameter int LINE_LIMIT = LINE_LIMIT_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_wr_en,
   input  wire logic [6:0]   csr_wr_data,
   irc_lfp_req_if.sink       req_if,
   input  q_status_type      q_stat,
   output logic              push,
   output q_entry_type       entry
);

   localparam int CNT_W = $clog2(LINE_LIMIT + 2);
   localparam logic [CNT_W-1:0] LIMIT = CNT_W'(LINE_LIMIT);

   function automatic logic [FIELD_W-1:0] fit(input logic [CNT_W-1:0] v);
      logic [CNT_W+FIELD_W-1:0] w;
      w = {{FIELD_W{1'b0}}, v};
      return w[FIELD_W-1:0];
   endfunction

   logic [6:0]       mask_ff;
   phase_type        ph_ff, ph_in, ph_eff;
   logic [CNT_W-1:0] lc_ff, lc_in, seg_ff, seg_in;
   err_type          err_ff, err_in, err_eff;

   logic [7:0]       b;
   logic             accept, over, want;
   logic [CNT_W-1:0] lc_inc, lcm1, flen, lspan;
   ev_type           kind;
   logic [CNT_W-1:0] ev_start, ev_len;
   err_type          code;
   logic             pair, lf_end;

   assign req_if.ready = !q_stat.full;
   assign accept = req_if.valid && req_if.ready;
   assign b = req_if.data_byte;

   // Counter and span arithmetic, effective error code and phase
   always_comb begin
      lc_inc  = (lc_ff <= LIMIT) ? lc_ff + 1'b1 : lc_ff;
      over    = lc_inc > LIMIT;
      lcm1    = lc_inc - 1'b1;
      flen    = (lcm1 > seg_ff) ? lcm1 - seg_ff : '0;
      lspan   = (lc_ff > seg_ff) ? lc_ff - seg_ff : '0;
      err_eff = over ? ERR_LONG : err_ff;
      if (over)
         ph_eff = PH_ERROR;
      else if (ph_ff == PH_INIT && b != CH_COLON)
         ph_eff = PH_COMMAND;
      else
         ph_eff = ph_ff;
   end

   // Byte classification and next line state
   always_comb begin
      ph_in    = ph_ff;
      lc_in    = lc_ff;
      seg_in   = seg_ff;
      err_in   = err_ff;
      want     = 1'b0;
      lf_end   = 1'b0;
      kind     = EV_ERROR;
      ev_start = lcm1;
      ev_len   = flen;
      code     = ERR_NONE;
      if (b == CH_CR) begin
         ph_in = PH_END;
      end else if (b == CH_LF) begin
         if (ph_ff == PH_END) begin
            lf_end   = 1'b1;
            ev_start = seg_ff;
            ev_len   = lspan;
            ph_in    = PH_INIT;
            lc_in    = '0;
            seg_in   = '0;
            err_in   = ERR_NONE;
         end else begin
            want     = 1'b1;
            kind     = EV_ERROR;
            ev_start = lc_ff;
            ev_len   = '0;
            code     = ERR_LF;
         end
      end else begin
         lc_in  = lc_inc;
         err_in = err_eff;
         ph_in  = ph_eff;
         unique case (ph_eff)
            PH_INIT: begin
               seg_in = CNT_W'(1);
               ph_in  = PH_NICK;
            end
            PH_NICK: begin
               if (b == CH_AT || b == CH_SPACE || b == CH_BANG) begin
                  want     = 1'b1;
                  kind     = EV_NICK;
                  ev_start = seg_ff;
                  seg_in   = lc_inc;
                  if (b == CH_AT)
                     ph_in = PH_HOST;
                  else if (b == CH_SPACE)
                     ph_in = PH_COMMAND;
                  else
                     ph_in = PH_NAME;
               end
            end
            PH_NAME: begin
               if (b == CH_SPACE || b == CH_AT) begin
                  want     = 1'b1;
                  kind     = EV_NAME;
                  ev_start = seg_ff;
                  seg_in   = lc_inc;
                  ph_in    = (b == CH_SPACE) ? PH_COMMAND : PH_HOST;
               end
            end
            PH_HOST: begin
               if (b == CH_SPACE) begin
                  want     = 1'b1;
                  kind     = EV_HOST;
                  ev_start = seg_ff;
                  seg_in   = lc_inc;
                  ph_in    = PH_COMMAND;
               end
            end
            PH_COMMAND: begin
               if (b == CH_SPACE) begin
                  want     = 1'b1;
                  kind     = EV_COMMAND;
                  ev_start = seg_ff;
                  seg_in   = lc_inc;
                  ph_in    = PH_PARAMS;
               end
            end
            PH_PARAMS: begin
               if (b == CH_SPACE) begin
                  want     = 1'b1;
                  kind     = EV_PARAM;
                  ev_start = seg_ff;
                  seg_in   = lc_inc;
               end else if (b == CH_COLON && lc_inc == seg_ff + 1'b1) begin
                  ph_in  = PH_TRAILING;
                  seg_in = lc_inc;
               end
            end
            PH_TRAILING: begin
            end
            PH_END: begin
               ph_in  = PH_ERROR;
               err_in = ERR_AFTER_CR;
               want   = 1'b1;
               kind   = EV_ERROR;
               ev_len = CNT_W'(1);
               code   = ERR_AFTER_CR;
            end
            default: begin
               // error phase and unused phase codes
               ph_in  = PH_ERROR;
               want   = 1'b1;
               kind   = EV_ERROR;
               ev_len = CNT_W'(1);
               code   = err_eff;
            end
         endcase
      end
   end

   // Masking and queue entry; a line end carries param and end of line together
   always_comb begin
      entry.start = fit(ev_start);
      entry.len   = fit(ev_len);
      entry.code  = code;
      if (lf_end) begin
         entry.kind = mask_ff[EV_PARAM] ? EV_PARAM : EV_END;
         entry.pair = mask_ff[EV_PARAM] && mask_ff[EV_END];
         push       = accept && (mask_ff[EV_PARAM] || mask_ff[EV_END]);
      end else begin
         entry.kind = kind;
         entry.pair = 1'b0;
         push       = accept && want && mask_ff[kind];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= 7'h7F;
         ph_ff   <= PH_INIT;
         lc_ff   <= '0;
         seg_ff  <= '0;
         err_ff  <= ERR_NONE;
      end else begin
         if (csr_wr_en)
            mask_ff <= csr_wr_data;
         if (accept) begin
            ph_ff  <= ph_in;
            lc_ff  <= lc_in;
            seg_ff <= seg_in;
            err_ff <= err_in;
         end
      end
   end

`ifndef SYNTHESIS
   a_overlong_err: assert property (@(posedge clock) disable iff (reset)
      (lc_ff > LIMIT) |-> (ph_ff == PH_ERROR || ph_ff == PH_END))
      else $error("overlong line outside error handling");
   a_seg_order: assert property (@(posedge clock) disable iff (reset)
      seg_ff <= lc_ff)
      else $error("segment start beyond line count");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_stat.full)
      else $error("push into full queue");
`endif

endmodule
`default_nettype wire

[rtl/irc_lfp_queue.sv]
`default_nettype none
module irc_lfp_queue
   import irc_lfp_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire q_entry_type   push_entry,
   input  wire logic          pop,
   output q_entry_type        head,
   output q_status_type       status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   q_entry_type      slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, rd_ff;
   logic [CNT_W-1:0] cnt_ff;

   assign status.full  = cnt_ff == FULL_CNT;
   assign status.empty = cnt_ff == '0;
   assign head = slot_ff[rd_ff];

   // Entry storage
   always_ff @(posedge clock) begin
      if (push)
         slot_ff[wr_ff] <= push_entry;
   end

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push)
            wr_ff <= (wr_ff == LAST) ? '0 : wr_ff + 1'b1;
         if (pop)
            rd_ff <= (rd_ff == LAST) ? '0 : rd_ff + 1'b1;
         if (push && !pop)
            cnt_ff <= cnt_ff + 1'b1;
         else if (pop && !push)
            cnt_ff <= cnt_ff - 1'b1;
      end
   end

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FULL_CNT)
      else $error("queue count overflow");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

[rtl/irc_lfp_back.sv]
`default_nettype none
module irc_lfp_back
   import irc_lfp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire q_entry_type  head,
   input  wire q_status_type q_stat,
   output logic              pop,
   irc_lfp_rsp_if.source     rsp_if
);

   logic               valid_ff;
   logic               sub_ff;
   ev_type             kind_ff;
   logic [FIELD_W-1:0] start_ff, len_ff;
   err_type            code_ff;
   logic               last_ff;
   logic               load;

   // Output slot free or being drained this cycle, and an entry queued
   assign load = (!valid_ff || rsp_if.ready) && !q_stat.empty;
   assign pop  = load && (sub_ff || !head.pair);

   assign rsp_if.valid        = valid_ff;
   assign rsp_if.event_kind   = kind_ff;
   assign rsp_if.field_start  = start_ff;
   assign rsp_if.field_length = len_ff;
   assign rsp_if.error_code   = code_ff;
   assign rsp_if.last_of_run  = last_ff;

   // Control: output valid and second-beat flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sub_ff   <= 1'b0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            sub_ff   <= !sub_ff && head.pair;
         end else if (rsp_if.ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // Payload: first beat is the queued kind, second beat is end of line
   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff  <= sub_ff ? EV_END : head.kind;
         start_ff <= head.start;
         len_ff   <= head.len;
         code_ff  <= head.code;
         last_ff  <= sub_ff || !head.pair;
      end
   end

`ifndef SYNTHESIS
   a_sub_has_head: assert property (@(posedge clock) disable iff (reset)
      sub_ff |-> !q_stat.empty)
      else $error("pending end-of-line beat without queued entry");
   a_sub_after_param: assert property (@(posedge clock) disable iff (reset)
      sub_ff |-> (valid_ff && kind_ff == EV_PARAM && !last_ff))
      else $error("end-of-line beat not preceded by param beat");
`endif

endmodule
`default_nettype wire

[rtl/irc_line_field_parser.sv]
`default_nettype none
// IRC line field parser.
// req_if takes one byte of the message stream per beat (valid/ready).
// rsp_if gives field events: kind, start offset, length, error code and a
// last_of_run flag that marks the final beat caused by one byte.
// csr_wr_en/csr_wr_data write the 7-bit event mask; a cleared bit drops
// that event kind. Write it only while no bytes are in flight.
// Throughput: one byte per cycle while the command queue has room. Most
// bytes give zero or one beat; the LF that ends a line gives a param beat
// and an end-of-line beat, which the output stage sends in turn.
// A beat caused by an accepted byte goes from the front parser into the
// command queue and from the queue into the output register. A command
// queue of QUEUE_DEPTH entries (default 4) between parser and output stage
// absorbs stalls; req_if.ready drops only when that queue is full, so a
// stalled receiver backs up the queue before the byte stream stops.
// Reset (synchronous): mask all ones, parser at start of line, queue and
// output register empty.
module irc_line_field_parser
   import irc_lfp_pkg::*;
#(
   parameter int LINE_LIMIT  = LINE_LIMIT_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_wr_en,
   input  wire logic [6:0] csr_wr_data,
   irc_lfp_req_if.sink     req_if,
   irc_lfp_rsp_if.source   rsp_if
);

   logic         push, pop;
   q_entry_type  push_entry, head;
   q_status_type q_stat;

   irc_lfp_front #(
      .LINE_LIMIT (LINE_LIMIT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_if      (req_if),
      .q_stat      (q_stat),
      .push        (push),
      .entry       (push_entry)
   );

   irc_lfp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_stat)
   );

   irc_lfp_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .q_stat (q_stat),
      .pop    (pop),
      .rsp_if (rsp_if)
   );

endmodule
`default_nettype wire

[tb/irc_line_field_parser_checker.sv]
`default_nettype none
// Watches the byte and event channels of the parser, predicts the field
// events for every accepted byte and compares each event beat in order.
module irc_line_field_parser_checker
   import irc_lfp_pkg::*;
#(
   parameter int LINE_LIMIT = LINE_LIMIT_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_wr_en,
   input  wire logic [6:0] csr_wr_data,
   irc_lfp_req_if          req_if,
   irc_lfp_rsp_if          rsp_if,
   output int              fail_count,
   output int              pending,
   output int              beats_seen
);

   typedef struct packed {
      ev_type               kind;
      logic [FIELD_W-1:0]   start;
      logic [FIELD_W-1:0]   len;
      err_type              code;
      logic                 last;
   } field_event_type;

   // Mirror of the parser state and the event mask
   logic [6:0]  event_mask;
   phase_type   parse_phase;
   int unsigned line_pos;
   int unsigned seg_start;
   err_type     err_status;

   field_event_type run_events[$];
   field_event_type expected_events[$];

   function automatic int unsigned span_to(int unsigned end_pos);
      return (end_pos > seg_start) ? end_pos - seg_start : 0;
   endfunction

   task automatic start_line();
      parse_phase = PH_INIT;
      line_pos    = 0;
      seg_start   = 0;
      err_status  = ERR_NONE;
   endtask

   // Masked kinds are dropped; never more than two events per byte
   task automatic add_event(ev_type kind, int unsigned start, int unsigned len,
                            err_type code);
      field_event_type ev;
      if (event_mask[kind] && run_events.size() < 2) begin
         ev.kind  = kind;
         ev.start = start[FIELD_W-1:0];
         ev.len   = len[FIELD_W-1:0];
         ev.code  = code;
         ev.last  = 1'b0;
         run_events.push_back(ev);
      end
   endtask

   // Field events caused by one byte
   task automatic predict_byte(logic [7:0] b);
      int unsigned flen;
      run_events.delete();
      if (b == CH_CR) begin
         parse_phase = PH_END;
      end else if (b == CH_LF) begin
         if (parse_phase == PH_END) begin
            // CR LF: last segment as a param, then end of line
            flen = span_to(line_pos);
            add_event(EV_PARAM, seg_start, flen, ERR_NONE);
            add_event(EV_END, seg_start, flen, ERR_NONE);
            start_line();
         end else begin
            // bare LF leaves the state alone
            add_event(EV_ERROR, line_pos, 0, ERR_LF);
         end
      end else begin
         if (line_pos <= LINE_LIMIT) line_pos++;
         if (line_pos > LINE_LIMIT) begin
            parse_phase = PH_ERROR;
            err_status  = ERR_LONG;
         end
         if (parse_phase == PH_INIT && b != CH_COLON) parse_phase = PH_COMMAND;
         flen = span_to(line_pos - 1);
         case (parse_phase)
            PH_INIT: begin
               seg_start   = 1;
               parse_phase = PH_NICK;
            end
            PH_NICK: begin
               if (b == CH_AT || b == CH_SPACE || b == CH_BANG) begin
                  add_event(EV_NICK, seg_start, flen, ERR_NONE);
                  if (b == CH_AT) parse_phase = PH_HOST;
                  else if (b == CH_SPACE) parse_phase = PH_COMMAND;
                  else parse_phase = PH_NAME;
                  seg_start = line_pos;
               end
            end
            PH_NAME: begin
               if (b == CH_SPACE || b == CH_AT) begin
                  add_event(EV_NAME, seg_start, flen, ERR_NONE);
                  if (b == CH_SPACE) parse_phase = PH_COMMAND;
                  else parse_phase = PH_HOST;
                  seg_start = line_pos;
               end
            end
            PH_HOST: begin
               if (b == CH_SPACE) begin
                  add_event(EV_HOST, seg_start, flen, ERR_NONE);
                  parse_phase = PH_COMMAND;
                  seg_start   = line_pos;
               end
            end
            PH_COMMAND: begin
               if (b == CH_SPACE) begin
                  add_event(EV_COMMAND, seg_start, flen, ERR_NONE);
                  parse_phase = PH_PARAMS;
                  seg_start   = line_pos;
               end
            end
            PH_PARAMS: begin
               if (b == CH_SPACE) begin
                  add_event(EV_PARAM, seg_start, flen, ERR_NONE);
                  seg_start = line_pos;
               end else if (b == CH_COLON && line_pos == seg_start + 1) begin
                  // colon opening a param starts the trailing part
                  parse_phase = PH_TRAILING;
                  seg_start   = line_pos;
               end
            end
            PH_TRAILING: ;
            PH_END: begin
               // ordinary byte between CR and LF
               parse_phase = PH_ERROR;
               err_status  = ERR_AFTER_CR;
               add_event(EV_ERROR, line_pos - 1, 1, err_status);
            end
            default: begin
               parse_phase = PH_ERROR;
               add_event(EV_ERROR, line_pos - 1, 1, err_status);
            end
         endcase
      end
      if (run_events.size() > 0) run_events[run_events.size()-1].last = 1'b1;
      foreach (run_events[i]) expected_events.push_back(run_events[i]);
   endtask

   // Compare one accepted event beat with the oldest expectation
   task automatic check_beat();
      field_event_type want;
      beats_seen++;
      if (expected_events.size() == 0) begin
         fail_count++;
         $display("%0t: expected no beat, got kind=%0d start=%0d len=%0d code=%0d last=%0b",
                  $time, rsp_if.event_kind, rsp_if.field_start,
                  rsp_if.field_length, rsp_if.error_code, rsp_if.last_of_run);
      end else begin
         want = expected_events.pop_front();
         if (rsp_if.event_kind !== want.kind || rsp_if.field_start !== want.start ||
             rsp_if.field_length !== want.len || rsp_if.error_code !== want.code ||
             rsp_if.last_of_run !== want.last) begin
            fail_count++;
            $display("%0t: expected kind=%0d start=%0d len=%0d code=%0d last=%0b,",
                     $time, want.kind, want.start, want.len, want.code, want.last);
            $display("%0t:      got kind=%0d start=%0d len=%0d code=%0d last=%0b",
                     $time, rsp_if.event_kind, rsp_if.field_start,
                     rsp_if.field_length, rsp_if.error_code, rsp_if.last_of_run);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         event_mask = 7'h7F;
         start_line();
         expected_events.delete();
      end else begin
         if (csr_wr_en) event_mask = csr_wr_data;
         if (req_if.valid && req_if.ready) predict_byte(req_if.data_byte);
         if (rsp_if.valid && rsp_if.ready) check_beat();
      end
      pending = expected_events.size();
   end

endmodule
`default_nettype wire

[tb/irc_line_field_parser_test.sv]
`default_nettype none
module irc_line_field_parser_test;
   import irc_lfp_pkg::*;

   localparam int HOLD_CYCLES = 60;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_wr_en;
   logic [6:0] csr_wr_data;

   irc_lfp_req_if req_ch();
   irc_lfp_rsp_if rsp_ch();

   int fail_count;
   int pending;
   int beats_seen;

   int         send_gap_max = 0;
   int         recv_gap_max = 0;
   bit         hold_rsp = 1'b0;
   int         bytes_sent = 0;
   int         mask_writes = 0;
   logic [7:0] line_bytes[$];

   always #5 clock = ~clock;

   irc_line_field_parser dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch)
   );

   irc_line_field_parser_checker chk (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .fail_count  (fail_count),
      .pending     (pending),
      .beats_seen  (beats_seen)
   );

   // Mostly no wait; otherwise a random wait bounded by gap_max
   function automatic int draw_gap(int gap_max);
      if (gap_max == 0 || $urandom_range(0, 2) != 0) return 0;
      return $urandom_range(0, gap_max);
   endfunction

   // Any byte that is not a line or field delimiter
   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (b == CH_CR || b == CH_LF || b == CH_SPACE || b == CH_BANG ||
             b == CH_AT || b == CH_COLON);
      return b;
   endfunction

   function automatic logic [7:0] noise_byte();
      case ($urandom_range(0, 9))
         0: return CH_CR;
         1: return CH_LF;
         2: return CH_COLON;
         3: return CH_BANG;
         4: return CH_AT;
         5: return CH_SPACE;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
   endtask

   task automatic add_word(int max_len);
      repeat ($urandom_range(0, max_len)) line_bytes.push_back(plain_byte());
   endtask

   task automatic add_crlf();
      line_bytes.push_back(CH_CR);
      line_bytes.push_back(CH_LF);
   endtask

   // One random line: mostly well formed, sometimes plain noise
   task automatic build_line();
      logic [7:0] b;
      if ($urandom_range(0, 9) < 7) begin
         if ($urandom_range(0, 1)) begin
            line_bytes.push_back(CH_COLON);
            add_word(6);
            if ($urandom_range(0, 1)) begin
               line_bytes.push_back(CH_BANG);
               add_word(6);
            end
            if ($urandom_range(0, 1)) begin
               line_bytes.push_back(CH_AT);
               add_word(8);
            end
            line_bytes.push_back(CH_SPACE);
         end
         add_word(6);
         repeat ($urandom_range(0, 4)) begin
            line_bytes.push_back(CH_SPACE);
            add_word(5);
         end
         if ($urandom_range(0, 1)) begin
            line_bytes.push_back(CH_SPACE);
            line_bytes.push_back(CH_COLON);
            repeat ($urandom_range(0, 10)) begin
               do b = 8'($urandom_range(0, 255)); while (b == CH_CR || b == CH_LF);
               line_bytes.push_back(b);
            end
         end
         case ($urandom_range(0, 7))
            0: line_bytes.push_back(CH_LF);
            1: begin
               line_bytes.push_back(CH_CR);
               line_bytes.push_back(plain_byte());
               add_crlf();
            end
            default: add_crlf();
         endcase
      end else begin
         repeat ($urandom_range(1, 16)) line_bytes.push_back(noise_byte());
      end
   endtask

   // Offer each byte, holding it until the parser takes it
   task automatic send_line();
      int gap;
      foreach (line_bytes[i]) begin
         gap = draw_gap(send_gap_max);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_ch.valid     <= 1'b1;
         req_ch.data_byte <= line_bytes[i];
         do @(posedge clock); while (!req_ch.ready);
      end
      bytes_sent += line_bytes.size();
      line_bytes.delete();
   endtask

   // Stop offering, let every event come out, then leave room for the pipeline
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_mask(logic [6:0] m);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      mask_writes++;
   endtask

   // Event receiver with random back-pressure and an occasional long hold
   task automatic run_receiver();
      int gap;
      forever begin
         if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end
         gap = draw_gap(recv_gap_max);
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   endtask

   initial begin
      logic [6:0] phase_masks[6];
      int         phase_bytes;
      int         drain_cycles;

      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      req_ch.valid     = 1'b0;
      req_ch.data_byte = '0;
      rsp_ch.ready     = 1'b0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      fork
         run_receiver();
      join_none

      // Directed lines: full prefix, bare LF, byte after CR, nick closed by space
      set_mask(7'h7F);
      send_gap_max = 17;
      recv_gap_max = 17;
      add_text(":n!u@h C p :t");
      add_crlf();
      line_bytes.push_back(CH_LF);
      line_bytes.push_back(8'hFF);
      line_bytes.push_back(CH_CR);
      line_bytes.push_back(8'h00);
      add_crlf();
      add_text(":a b");
      add_crlf();
      send_line();

      // Random lines under several masks and idling mixes
      phase_masks = '{7'h00, 7'h55, 7'h2A, 7'h7F, 7'h10, 7'h7F};
      phase_masks[3] = 7'($urandom_range(0, 127));
      for (int p = 0; p < 6; p++) begin
         set_mask(phase_masks[p]);
         send_gap_max = (p % 3 == 1) ? 0 : 17;
         recv_gap_max = (p % 3 == 2) ? 0 : 17;
         if (p == 1) begin
            // param events pile up behind a stalled receiver
            hold_rsp = 1'b1;
            add_crlf();
            line_bytes.push_back(8'h50);
            repeat (20) line_bytes.push_back(CH_SPACE);
            add_crlf();
            send_line();
         end
         phase_bytes = 0;
         while (phase_bytes < 10) begin
            build_line();
            phase_bytes += line_bytes.size();
            send_line();
         end
      end

      // Overlong line: runs through the last legal count into the error phase
      send_gap_max = 0;
      recv_gap_max = 0;
      add_crlf();
      repeat (LINE_LIMIT_DEF + 4) line_bytes.push_back(plain_byte());
      add_crlf();
      send_line();

      req_ch.valid <= 1'b0;
      drain_cycles = 0;
      while (pending != 0 && drain_cycles < 4000) begin
         @(negedge clock);
         drain_cycles++;
      end
      repeat (4) @(posedge clock);
      $display("run covered %0d bytes under %0d mask writes; %0d event beats checked",
               bytes_sent, mask_writes, beats_seen);
      if (fail_count == 0 && pending == 0)
         $display("irc_line_field_parser: match");
      else
         $display("irc_line_field_parser: mismatch");
      $finish;
   end

   // Watchdog
   initial begin
      #5000000;
      $display("irc_line_field_parser: mismatch");
      $finish;
   end

endmodule
`default_nettype wire
